// ----- rtl/core/swrsi_pkg.sv -----
// ----------------------------------------------------------------------------
// swrsi_pkg
// Word types and fixed constants of the sliding-window RSI block.
// ----------------------------------------------------------------------------
package swrsi_pkg;

  // fixed field widths of the channel words
  localparam int PRICE_W = 32;
  localparam int RSI_W   = 15;
  localparam int CFG_W   = 7;

  // window length after reset
  localparam logic [CFG_W-1:0] CFG_WLEN_RESET = 7'd14;

  // RSI full scale is 100 * 256; flat windows report 50 * 256
  localparam logic [RSI_W-1:0] RSI_FULL_SCALE = 15'd25600;
  localparam logic [RSI_W-1:0] RSI_HALF_SCALE = 15'd12800;

  // quotient bits produced by the divider (result < 2^15)
  localparam int QUO_BITS = RSI_W;

  // input word
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               restart;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [RSI_W-1:0] rsi_scaled;
    logic             flat;
  } out_word_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_UPD  = 5'b00010,
    ST_CALC = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_RND  = 5'b10000
  } state_t;

endpackage

// ----- rtl/core/sliding_window_rsi.sv -----
// ----------------------------------------------------------------------------
// sliding_window_rsi
// Simple-average RSI over a sliding window of prices, change history in RAM.
// ----------------------------------------------------------------------------
// A price with a result goes through UPD, CALC, the 15-step restoring divider (DIV)
//   and RND, where out_stall can hold it; a flat window skips DIV. While the window
//   fills a price goes through UPD only; the first price of a series stays in IDLE.
//   No price is taken outside IDLE; the history RAM is read then and written in UPD.
// Reset (rst_n, synchronous): window length 14, no history, no pending word; the
//   history RAM is not cleared, the fill count guards every read.
module sliding_window_rsi #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  swrsi_pkg::in_word_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output swrsi_pkg::out_word_t          out_data,
  input  logic                          cfg_we,
  input  logic [swrsi_pkg::CFG_W-1:0]   cfg_wdata
);
  import swrsi_pkg::*;

  // derived widths
  localparam int PTR_W  = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
  localparam int WCNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CW     = (WCNT_W > CFG_W) ? WCNT_W : CFG_W;
  localparam int IW     = CW + 1;
  localparam int CH_W   = PRICE_BITS + 1;
  localparam int SUM_W  = PRICE_BITS + PTR_W;
  localparam int N_W    = SUM_W + QUO_BITS;
  localparam int PX     = (PRICE_BITS > PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int CNT_W  = $clog2(QUO_BITS);

  // registers
  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        wlen_r, wlen_nxt;
  logic [PRICE_BITS-1:0]   prev_r, prev_nxt;
  logic [SUM_W-1:0]        up_r, up_nxt;
  logic [SUM_W-1:0]        dn_r, dn_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [PTR_W-1:0]        ptr_r, ptr_nxt;
  logic signed [CH_W-1:0]  chg_r, chg_nxt;
  logic                    sub_r, sub_nxt;
  logic [SUM_W-1:0]        t_r, t_nxt;
  logic [SUM_W-1:0]        rem_r, rem_nxt;
  logic [QUO_BITS-1:0]     nlo_r, nlo_nxt;
  logic [QUO_BITS-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    flat_r, flat_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r, out_data_nxt;

  // history RAM
  logic signed [CH_W-1:0]  hist_mem [MAX_WINDOW];
  logic signed [CH_W-1:0]  rd_q;
  logic                    rd_en;
  logic [PTR_W-1:0]        rd_addr;
  logic                    wr_en;

  // combinational helpers
  logic [PX-1:0]           price_x;
  logic [PRICE_BITS-1:0]   price_m;
  logic [CW-1:0]           wlen_x, w_eff;
  logic [CW-1:0]           fill_eff;
  logic [IW-1:0]           ptr_e, wm1, old_idx;
  logic                    in_take;
  logic signed [CH_W-1:0]  new_neg, old_neg;
  logic [PRICE_BITS-1:0]   new_mag, old_mag;
  logic                    new_pos, old_pos;
  logic [N_W-1:0]          n_full;
  logic [SUM_W:0]          div_sh;
  logic                    div_ge;
  logic                    rnd_up;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // price masked to the configured width
  assign price_x = PX'(in_data.price);
  assign price_m = price_x[PRICE_BITS-1:0];

  // window length clamped to 2..MAX_WINDOW
  assign wlen_x = CW'(wlen_r);
  always_comb begin
    if (wlen_x < CW'(2)) begin
      w_eff = CW'(2);
    end else if (wlen_x > CW'(MAX_WINDOW)) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = wlen_x;
    end
  end

  assign fill_eff = in_data.restart ? '0 : fill_r;

  // entry leaving the window: ptr - (w - 1), modulo the RAM depth
  assign ptr_e = IW'(ptr_r);
  assign wm1   = IW'(w_eff) - IW'(1);
  assign old_idx = (ptr_e >= wm1) ? (ptr_e - wm1) : (ptr_e + IW'(MAX_WINDOW) - wm1);

  // magnitudes of the entering and leaving changes
  assign new_neg = -chg_r;
  assign old_neg = -rd_q;
  assign new_pos = !chg_r[CH_W-1] && (chg_r != '0);
  assign old_pos = !rd_q[CH_W-1] && (rd_q != '0);
  assign new_mag = chg_r[CH_W-1] ? new_neg[PRICE_BITS-1:0] : chg_r[PRICE_BITS-1:0];
  assign old_mag = rd_q[CH_W-1] ? old_neg[PRICE_BITS-1:0] : rd_q[PRICE_BITS-1:0];

  // 25600 * U as shifts: 25600 = 2^14 + 2^13 + 2^10
  assign n_full = (N_W'(up_r) << 14) + (N_W'(up_r) << 13) + (N_W'(up_r) << 10);

  // one restoring divide step
  assign div_sh = {rem_r, nlo_r[QUO_BITS-1]};
  assign div_ge = (div_sh >= {1'b0, t_r});

  // round half up: 2*rem >= T
  assign rnd_up = ({rem_r, 1'b0} >= {1'b0, t_r});

  // RAM ports
  assign rd_en   = in_take && (fill_eff != '0);
  assign rd_addr = old_idx[PTR_W-1:0];
  assign wr_en   = (state_r == ST_UPD);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[ptr_r] <= chg_r;
    end
    if (rd_en) begin
      rd_q <= hist_mem[rd_addr];
    end
  end

  // sequencer and datapath
  always_comb begin
    state_nxt     = state_r;
    wlen_nxt      = wlen_r;
    prev_nxt      = prev_r;
    up_nxt        = up_r;
    dn_nxt        = dn_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    chg_nxt       = chg_r;
    sub_nxt       = sub_r;
    t_nxt         = t_r;
    rem_nxt       = rem_r;
    nlo_nxt       = nlo_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    flat_nxt      = flat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_we) begin
          // new window length starts a new series
          wlen_nxt = cfg_wdata;
          fill_nxt = '0;
          up_nxt   = '0;
          dn_nxt   = '0;
          ptr_nxt  = '0;
        end else if (in_take) begin
          prev_nxt = price_m;
          if (fill_eff == '0) begin
            // first price of a series
            fill_nxt = CW'(1);
            if (in_data.restart) begin
              up_nxt  = '0;
              dn_nxt  = '0;
              ptr_nxt = '0;
            end
          end else begin
            chg_nxt   = $signed({1'b0, price_m}) - $signed({1'b0, prev_r});
            sub_nxt   = (fill_r >= w_eff);
            state_nxt = ST_UPD;
          end
        end
      end

      ST_UPD: begin
        // drop the leaving change, add the entering one
        up_nxt = up_r - ((sub_r && old_pos) ? SUM_W'(old_mag) : '0)
                      + (new_pos ? SUM_W'(new_mag) : '0);
        dn_nxt = dn_r - ((sub_r && !old_pos) ? SUM_W'(old_mag) : '0)
                      + (!new_pos ? SUM_W'(new_mag) : '0);
        ptr_nxt = (ptr_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_r + PTR_W'(1);
        if (fill_r < w_eff) begin
          fill_nxt = fill_r + CW'(1);
        end
        if ((fill_r + CW'(1)) >= w_eff) begin
          state_nxt = ST_CALC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_CALC: begin
        // load divider with 25600*U over T = U + D
        t_nxt    = up_r + dn_r;
        flat_nxt = ((up_r + dn_r) == '0);
        rem_nxt  = n_full[N_W-1:QUO_BITS];
        nlo_nxt  = n_full[QUO_BITS-1:0];
        quo_nxt  = '0;
        cnt_nxt  = CNT_W'(QUO_BITS - 1);
        state_nxt = ((up_r + dn_r) == '0) ? ST_RND : ST_DIV;
      end

      ST_DIV: begin
        rem_nxt = div_ge ? SUM_W'(div_sh - {1'b0, t_r}) : div_sh[SUM_W-1:0];
        nlo_nxt = {nlo_r[QUO_BITS-2:0], 1'b0};
        quo_nxt = {quo_r[QUO_BITS-2:0], div_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_RND;
        end
      end

      ST_RND: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.flat       = flat_r;
          out_data_nxt.rsi_scaled = flat_r ? RSI_HALF_SCALE
                                           : quo_r + QUO_BITS'(rnd_up);
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wlen_r      <= CFG_WLEN_RESET;
      prev_r      <= '0;
      up_r        <= '0;
      dn_r        <= '0;
      fill_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wlen_r      <= wlen_nxt;
      prev_r      <= prev_nxt;
      up_r        <= up_nxt;
      dn_r        <= dn_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chg_r      <= chg_nxt;
    sub_r      <= sub_nxt;
    t_r        <= t_nxt;
    rem_r      <= rem_nxt;
    nlo_r      <= nlo_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    flat_r     <= flat_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.rsi_scaled <= RSI_FULL_SCALE))
    else $error("rsi_scaled above full scale");

  a_flat_half: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.flat) |-> (out_data_r.rsi_scaled == RSI_HALF_SCALE))
    else $error("flat word without half scale");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_eff)
    else $error("fill count beyond window");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < t_r))
    else $error("divider remainder not below divisor");

endmodule
